### src/dgt_pkg.sv
`default_nettype none

package dgt_pkg;

    // Framing constants
    localparam int MAX_DATAGRAM = 2048;
    localparam int HEADER_BYTES = 20;
    localparam int SEQ_POS      = 10;
    localparam int CNT_POS      = 18;
    localparam int COUNTER_BITS = 32;
    localparam int FIFO_DEPTH   = 4;

    localparam int POS_W  = $clog2(MAX_DATAGRAM + 1);
    localparam int CNT_W  = COUNTER_BITS;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] offset;
        logic        msg_end;
        logic [63:0] seq;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] packets;
        logic [CNT_W-1:0] messages;
        logic [CNT_W-1:0] gaps;
        logic [CNT_W-1:0] lost;
        logic [CNT_W-1:0] dups;
    } counters_t;

    // One queue entry: the results of one byte, with the counters after it
    typedef struct packed {
        logic [1:0]       num;
        result_t [1:0]    res;
        counters_t        cnt;
    } entry_t;

    function automatic logic [31:0] out32(input logic [CNT_W-1:0] c);
        logic [63:0] t;
        t = 64'(c);
        return t[31:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

### src/dgt_front.sv
`default_nettype none

module dgt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_datagram,
    output logic                   wr_en,
    output dgt_pkg::entry_t        wr_entry
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_SKIP
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [dgt_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [63:0]                  hseq_reg, hseq_next;
    logic [15:0]                  htot_reg, htot_next;
    logic                         hdone_reg, hdone_next;
    logic [63:0]                  exp_reg, exp_next;
    logic                         expv_reg, expv_next;
    logic [15:0]                  len_reg, len_next;
    logic [15:0]                  off_reg, off_next;
    logic [15:0]                  left_reg, left_next;
    logic [63:0]                  cur_reg, cur_next;
    logic                         gt_reg, gt_next;
    logic                         lt_reg, lt_next;
    logic [63:0]                  diff_reg, diff_next;
    dgt_pkg::counters_t           cnt_reg, cnt_next;

    logic [63:0]                  cmp_exp;
    logic [dgt_pkg::CNT_W:0]      lost_sum;
    logic                         lost_big;
    logic                         do_msg;
    logic                         pend;
    logic [15:0]                  pend_off;
    logic [1:0]                   num;
    dgt_pkg::result_t [1:0]       res;
    logic [63:0]                  sum_seq;

    // Classify the byte and work out the next parser state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hseq_next  = hseq_reg;
        htot_next  = htot_reg;
        hdone_next = hdone_reg;
        exp_next   = exp_reg;
        expv_next  = expv_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        gt_next    = gt_reg;
        lt_next    = lt_reg;
        diff_next  = diff_reg;
        cnt_next   = cnt_reg;
        cmp_exp    = expv_reg ? exp_reg : hseq_reg;
        lost_sum   = {1'b0, cnt_reg.lost} + {1'b0, diff_reg[dgt_pkg::CNT_W-1:0]};
        lost_big   = (diff_reg >> dgt_pkg::CNT_W) != 64'd0;
        do_msg     = 1'b0;
        pend       = 1'b0;
        pend_off   = 16'd0;
        num        = 2'd0;
        res        = '0;
        sum_seq    = 64'd0;

        if (pos_reg < dgt_pkg::POS_W'(dgt_pkg::MAX_DATAGRAM))
        begin
            pos_next = pos_reg + dgt_pkg::POS_W'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg >= dgt_pkg::POS_W'(dgt_pkg::SEQ_POS)
                        && pos_reg < dgt_pkg::POS_W'(dgt_pkg::SEQ_POS + 8))
                        hseq_next = {hseq_reg[55:0], data_byte};
                    else if (pos_reg >= dgt_pkg::POS_W'(dgt_pkg::CNT_POS)
                        && pos_reg < dgt_pkg::POS_W'(dgt_pkg::CNT_POS + 2))
                        htot_next = {htot_reg[7:0], data_byte};
                    // Sequence is complete here: compare one byte early
                    if (pos_reg == dgt_pkg::POS_W'(dgt_pkg::SEQ_POS + 8))
                    begin
                        gt_next   = hseq_reg > cmp_exp;
                        lt_next   = hseq_reg < cmp_exp;
                        diff_next = hseq_reg - cmp_exp;
                    end
                    if (pos_reg == dgt_pkg::POS_W'(dgt_pkg::HEADER_BYTES - 1))
                    begin
                        hdone_next       = 1'b1;
                        cnt_next.packets = dgt_pkg::sat_inc(cnt_reg.packets);
                        if (!expv_reg)
                        begin
                            expv_next = 1'b1;
                            exp_next  = hseq_reg;
                        end
                        if (gt_reg)
                        begin
                            cnt_next.gaps = dgt_pkg::sat_inc(cnt_reg.gaps);
                            if (lost_big || lost_sum[dgt_pkg::CNT_W])
                                cnt_next.lost = {dgt_pkg::CNT_W{1'b1}};
                            else
                                cnt_next.lost = lost_sum[dgt_pkg::CNT_W-1:0];
                        end
                        if (lt_reg)
                        begin
                            cnt_next.dups = dgt_pkg::sat_inc(cnt_reg.dups);
                            phase_next    = PH_SKIP;
                        end
                        else
                        begin
                            exp_next   = hseq_reg + 64'(htot_next);
                            cur_next   = hseq_reg;
                            left_next  = htot_next;
                            phase_next = (htot_next != 16'd0) ? PH_LEN_HI : PH_SKIP;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    len_next   = {data_byte, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], data_byte};
                    off_next = 16'd0;
                    if ({len_reg[15:8], data_byte} == 16'd0)
                    begin
                        res[0] = '{kind: dgt_pkg::KIND_EMPTY, payload: 8'd0, offset: 16'd0,
                                   msg_end: 1'b1, seq: cur_reg};
                        num    = 2'd1;
                        do_msg = 1'b1;
                    end
                    else
                        phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (({1'b0, off_reg} + 17'd1) == {1'b0, len_reg})
                    begin
                        res[0] = '{kind: dgt_pkg::KIND_BYTE, payload: data_byte,
                                   offset: off_reg, msg_end: 1'b1, seq: cur_reg};
                        num    = 2'd1;
                        do_msg = 1'b1;
                    end
                    else if (end_of_datagram)
                    begin
                        pend     = 1'b1;
                        pend_off = off_reg;
                        off_next = off_reg + 16'd1;
                    end
                    else
                    begin
                        res[0]   = '{kind: dgt_pkg::KIND_BYTE, payload: data_byte,
                                     offset: off_reg, msg_end: 1'b0, seq: cur_reg};
                        num      = 2'd1;
                        off_next = off_reg + 16'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Close out a complete message
        if (do_msg)
        begin
            cnt_next.messages = dgt_pkg::sat_inc(cnt_reg.messages);
            cur_next          = cur_reg + 64'd1;
            left_next         = left_reg - 16'd1;
            phase_next        = (left_reg != 16'd1) ? PH_LEN_HI : PH_SKIP;
        end

        // Report truncation and summary, then start over
        if (end_of_datagram)
        begin
            if (pend)
            begin
                res[num[0]] = '{kind: dgt_pkg::KIND_TRUNC, payload: data_byte,
                                offset: pend_off, msg_end: 1'b0, seq: cur_next};
                num = num + 2'd1;
            end
            else if (phase_next == PH_BODY)
            begin
                res[num[0]] = '{kind: dgt_pkg::KIND_TRUNC, payload: 8'd0,
                                offset: off_next, msg_end: 1'b0, seq: cur_next};
                num = num + 2'd1;
            end
            else if (phase_next == PH_LEN_LO)
            begin
                res[num[0]] = '{kind: dgt_pkg::KIND_TRUNC, payload: 8'd0,
                                offset: 16'd0, msg_end: 1'b0, seq: cur_next};
                num = num + 2'd1;
            end
            sum_seq     = hdone_next ? hseq_next : 64'd0;
            res[num[0]] = '{kind: dgt_pkg::KIND_SUMMARY, payload: 8'd0, offset: 16'd0,
                            msg_end: 1'b0, seq: sum_seq};
            num         = num + 2'd1;
            pos_next    = '0;
            phase_next  = PH_HEADER;
            hseq_next   = 64'd0;
            htot_next   = 16'd0;
            hdone_next  = 1'b0;
            len_next    = 16'd0;
            off_next    = 16'd0;
            left_next   = 16'd0;
            cur_next    = 64'd0;
        end
    end

    assign wr_en          = accept && (num != 2'd0);
    assign wr_entry.num   = num;
    assign wr_entry.res   = res;
    assign wr_entry.cnt   = cnt_next;

    // Hold parser state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            hseq_reg  <= 64'd0;
            htot_reg  <= 16'd0;
            hdone_reg <= 1'b0;
            exp_reg   <= 64'd0;
            expv_reg  <= 1'b0;
            len_reg   <= 16'd0;
            off_reg   <= 16'd0;
            left_reg  <= 16'd0;
            cur_reg   <= 64'd0;
            gt_reg    <= 1'b0;
            lt_reg    <= 1'b0;
            diff_reg  <= 64'd0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hseq_reg  <= hseq_next;
            htot_reg  <= htot_next;
            hdone_reg <= hdone_next;
            exp_reg   <= exp_next;
            expv_reg  <= expv_next;
            len_reg   <= len_next;
            off_reg   <= off_next;
            left_reg  <= left_next;
            cur_reg   <= cur_next;
            gt_reg    <= gt_next;
            lt_reg    <= lt_next;
            diff_reg  <= diff_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/dgt_back.sv
`default_nettype none

module dgt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire dgt_pkg::entry_t   wr_entry,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output dgt_pkg::result_t       head_res,
    output dgt_pkg::counters_t     head_cnt
);

    dgt_pkg::entry_t               mem [dgt_pkg::FIFO_DEPTH];
    logic [dgt_pkg::PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [dgt_pkg::FCNT_W-1:0]    count_reg, count_next;
    logic                          sel_reg;
    dgt_pkg::entry_t               head;
    logic                          take;
    logic                          retire;

    assign head     = mem[rd_ptr_reg];
    assign full     = count_reg == dgt_pkg::FCNT_W'(dgt_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign head_res = head.res[sel_reg];
    assign head_cnt = head.cnt;
    assign take     = pop && !empty;
    assign retire   = take && (sel_reg || head.num == 2'd1);

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !retire)
            count_next = count_reg + dgt_pkg::FCNT_W'(1);
        else if (!wr_en && retire)
            count_next = count_reg - dgt_pkg::FCNT_W'(1);
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_entry;
    end

    // Advance pointers; step through the results of the head entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + dgt_pkg::PTR_W'(1);
            if (retire)
            begin
                rd_ptr_reg <= rd_ptr_reg + dgt_pkg::PTR_W'(1);
                sel_reg    <= 1'b0;
            end
            else if (take)
                sel_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### src/datagram_deframer_gap_tracker.sv
// A result is queued as its byte is accepted and shown after earlier results pop.
// Throughput: one byte per cycle while the queue is not full; results leave one per
// cycle on pop; a two-result byte (datagram end) occupies the output for two pops.
// A four-entry queue between the parser and the output decouples the two sides.
// Reset (rst_n low, asynchronous) clears the parser, counters and queue.
`default_nettype none

module datagram_deframer_gap_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_datagram,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [15:0]      byte_offset,
    output logic             message_end,
    output logic [63:0]      message_sequence,
    output logic [31:0]      packet_count,
    output logic [31:0]      message_count,
    output logic [31:0]      gap_count,
    output logic [31:0]      lost_count,
    output logic [31:0]      duplicate_count
);

    logic                 accept;
    logic                 wr_en;
    dgt_pkg::entry_t      wr_entry;
    dgt_pkg::result_t     head_res;
    dgt_pkg::counters_t   head_cnt;

    assign accept = push && !full;

    dgt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .wr_en           (wr_en),
        .wr_entry        (wr_entry)
    );

    dgt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .head_res (head_res),
        .head_cnt (head_cnt)
    );

    assign kind             = head_res.kind;
    assign payload_byte     = head_res.payload;
    assign byte_offset      = head_res.offset;
    assign message_end      = head_res.msg_end;
    assign message_sequence = head_res.seq;
    assign packet_count     = dgt_pkg::out32(head_cnt.packets);
    assign message_count    = dgt_pkg::out32(head_cnt.messages);
    assign gap_count        = dgt_pkg::out32(head_cnt.gaps);
    assign lost_count       = dgt_pkg::out32(head_cnt.lost);
    assign duplicate_count  = dgt_pkg::out32(head_cnt.dups);

endmodule

`default_nettype wire

### src/dgt_checker.sv
`default_nettype none

module dgt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  payload_byte,
    input wire logic [15:0] byte_offset,
    input wire logic        message_end,
    input wire logic [63:0] message_sequence
);

    // A waiting beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(kind) && $stable(message_sequence))
        else $error("waiting result changed");

    a_empty_msg: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == dgt_pkg::KIND_EMPTY |-> message_end && payload_byte == 8'd0)
        else $error("empty message malformed");

    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == dgt_pkg::KIND_TRUNC |-> !message_end)
        else $error("truncated message marked complete");

    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && kind == dgt_pkg::KIND_SUMMARY |-> byte_offset == 16'd0 && !message_end)
        else $error("summary malformed");

endmodule

bind datagram_deframer_gap_tracker dgt_checker u_dgt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .pop              (pop),
    .kind             (kind),
    .payload_byte     (payload_byte),
    .byte_offset      (byte_offset),
    .message_end      (message_end),
    .message_sequence (message_sequence)
);

`default_nettype wire
